/* design/lcfs_pkg.sv */
// Shared types and constants of the largest-count-first selector.
package lcfs_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int LEAVES      = 1 << IDX_W;
    localparam int PORT_IDX_W  = 5;
    localparam int CMP_W       = ((IDX_W > PORT_IDX_W) ? IDX_W : PORT_IDX_W) + 1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TAKE = 1'b1
    } t_cmd;

    typedef logic [NUM_ENTRIES-1:0][COUNT_BITS-1:0] t_count_array;

    typedef struct packed {
        logic                  load_en;
        logic                  take_en;
        logic [PORT_IDX_W-1:0] load_idx;
        logic [COUNT_BITS-1:0] load_value;
        logic [IDX_W-1:0]      take_idx;
    } t_table_ctl;

endpackage

/* design/largest_count_first_selector.sv */
// Top level of the largest-count-first selector: handshake registers and assertions.
//
// The block keeps a table of per-entry counts, all zero after reset. A load
// transaction (cmd 0) writes count_value into entry entry_index; indices past
// the table are ignored. A take transaction (cmd 1) picks the entry with the
// largest nonzero count, the highest index among equals, returns it with found
// set and decrements that count; on an empty table it returns found 0 and
// index 0 and leaves the table alone. Every transaction yields exactly one
// result, and a load returns found 0 and index 0. The block accepts one
// transaction per cycle while the input is not stalled; its result shows at the
// outputs from the result register. While the transaction sits in the input
// register, the comparator tree and decrement read and update the count
// registers, and the result register captures the outcome as the transaction
// leaves the input register, so each take sees the effect of the transaction
// before it. While a result waits under stall, the input register can still
// take one more transaction; only after that is the input stalled.
module largest_count_first_selector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [lcfs_pkg::PORT_IDX_W-1:0]   i_entry_index,
    input  logic [15:0]                       i_count_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lcfs_pkg::PORT_IDX_W-1:0]   o_chosen_index,
    output logic                              o_found
);

    // Input register stage.
    logic                              r_in_valid;
    lcfs_pkg::t_cmd                    r_cmd;
    logic [lcfs_pkg::PORT_IDX_W-1:0]   r_idx;
    logic [15:0]                       r_value;

    // Result register stage.
    logic                              r_out_valid;
    logic [lcfs_pkg::PORT_IDX_W-1:0]   r_out_idx;
    logic                              r_out_found;

    logic                              w_out_free;
    logic                              w_adv;
    logic                              w_found;
    logic [lcfs_pkg::IDX_W-1:0]        w_pick;
    lcfs_pkg::t_count_array            w_counts;
    lcfs_pkg::t_table_ctl              w_ctl;
    logic                              w_take_hit;

    // The result register can take a new transaction when it is empty or
    // its current one leaves this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    // The table only changes on the cycle the transaction moves forward.
    assign w_take_hit       = w_adv && (r_cmd == lcfs_pkg::CMD_TAKE) && w_found;
    assign w_ctl.load_en    = w_adv && (r_cmd == lcfs_pkg::CMD_LOAD);
    assign w_ctl.take_en    = w_take_hit;
    assign w_ctl.load_idx   = r_idx;
    assign w_ctl.load_value = lcfs_pkg::COUNT_BITS'(r_value);
    assign w_ctl.take_idx   = w_pick;

    lcfs_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .o_counts (w_counts)
    );

    lcfs_argmax u_argmax (
        .i_counts (w_counts),
        .o_found  (w_found),
        .o_pick   (w_pick)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd   <= lcfs_pkg::t_cmd'(i_cmd);
            r_idx   <= i_entry_index;
            r_value <= i_count_value;
        end
        if (w_adv) begin
            if ((r_cmd == lcfs_pkg::CMD_TAKE) && w_found) begin
                r_out_idx   <= lcfs_pkg::PORT_IDX_W'(w_pick);
                r_out_found <= 1'b1;
            end else begin
                r_out_idx   <= '0;
                r_out_found <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_chosen_index = r_out_idx;
    assign o_found        = r_out_found;

    // A result without a found entry always reports index zero.
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_idx == '0))
        else $error("result without found carries a nonzero index");

    // The input stage only holds back the sender when it holds a transaction.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled while the input register is empty");

    // The picked entry always holds a nonzero count.
    a_pick_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_found |-> (w_counts[w_pick] != '0))
        else $error("comparator tree picked an empty entry");

    // A successful take lowers the picked count by exactly one.
    a_take_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_hit |=> (w_counts[$past(w_pick)] ==
            lcfs_pkg::COUNT_BITS'($past(w_counts[w_pick]) - lcfs_pkg::COUNT_BITS'(1))))
        else $error("take did not decrement the picked count");

endmodule

/* design/lcfs_table.sv */
// Count table: one register per entry, written by loads and decremented by takes.
module lcfs_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lcfs_pkg::t_table_ctl i_ctl,
    output lcfs_pkg::t_count_array o_counts
);

    lcfs_pkg::t_count_array r_counts;
    lcfs_pkg::t_count_array n_counts;

    // Loads and takes never occur together; each entry decodes its own write.
    always_comb begin
        n_counts = r_counts;
        for (int k = 0; k < lcfs_pkg::NUM_ENTRIES; k++) begin
            if (i_ctl.load_en &&
                (lcfs_pkg::CMP_W'(i_ctl.load_idx) == lcfs_pkg::CMP_W'(k))) begin
                n_counts[k] = i_ctl.load_value;
            end else if (i_ctl.take_en &&
                (lcfs_pkg::CMP_W'(i_ctl.take_idx) == lcfs_pkg::CMP_W'(k))) begin
                n_counts[k] = r_counts[k] - lcfs_pkg::COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '0;
        end else begin
            r_counts <= n_counts;
        end
    end

    assign o_counts = r_counts;

endmodule

/* design/lcfs_argmax.sv */
// Comparator tree that finds the highest-index entry holding the largest count.
module lcfs_argmax (
    input  lcfs_pkg::t_count_array        i_counts,
    output logic                          o_found,
    output logic [lcfs_pkg::IDX_W-1:0]    o_pick
);

    logic [lcfs_pkg::COUNT_BITS-1:0] w_cnt [lcfs_pkg::IDX_W+1][lcfs_pkg::LEAVES];
    logic [lcfs_pkg::IDX_W-1:0]      w_idx [lcfs_pkg::IDX_W+1][lcfs_pkg::LEAVES];

    // Padding leaves hold zero and can never win against a real nonzero count.
    for (genvar k = 0; k < lcfs_pkg::LEAVES; k++) begin : g_leaf
        if (k < lcfs_pkg::NUM_ENTRIES) begin : g_real
            assign w_cnt[0][k] = i_counts[k];
        end else begin : g_pad
            assign w_cnt[0][k] = '0;
        end
        assign w_idx[0][k] = lcfs_pkg::IDX_W'(k);
    end

    // The upper (higher-index) side wins ties, which matches a low-to-high scan.
    for (genvar lv = 0; lv < lcfs_pkg::IDX_W; lv++) begin : g_level
        for (genvar n = 0; n < (lcfs_pkg::LEAVES >> (lv + 1)); n++) begin : g_node
            logic w_hi_wins;
            assign w_hi_wins = (w_cnt[lv][2*n+1] >= w_cnt[lv][2*n]);
            assign w_cnt[lv+1][n] = w_hi_wins ? w_cnt[lv][2*n+1] : w_cnt[lv][2*n];
            assign w_idx[lv+1][n] = w_hi_wins ? w_idx[lv][2*n+1] : w_idx[lv][2*n];
        end
    end

    assign o_found = (w_cnt[lcfs_pkg::IDX_W][0] != '0);
    assign o_pick  = w_idx[lcfs_pkg::IDX_W][0];

endmodule
